### hdl/utf8v_pkg.sv
// ----------------------------------------------------------------------------
// utf8v_pkg
// Types and byte constants shared by the strict UTF-8 stream checker.
// ----------------------------------------------------------------------------
package utf8v_pkg;

    // byte masks and patterns
    localparam logic [7:0] C_MASK_TOP2   = 8'hc0;
    localparam logic [7:0] C_MASK_TOP3   = 8'he0;
    localparam logic [7:0] C_MASK_TOP4   = 8'hf0;
    localparam logic [7:0] C_MASK_TOP5   = 8'hf8;
    localparam logic [7:0] C_MASK_TOP7   = 8'hfe;
    localparam logic [7:0] C_CONT_TAG    = 8'h80;
    localparam logic [7:0] C_LEAD2_TAG   = 8'hc0;
    localparam logic [7:0] C_LEAD3_TAG   = 8'he0;
    localparam logic [7:0] C_LEAD4_TAG   = 8'hf0;

    // special lead and continuation values
    localparam logic [7:0] C_LEAD_E0     = 8'he0;
    localparam logic [7:0] C_LEAD_ED     = 8'hed;
    localparam logic [7:0] C_LEAD_EF     = 8'hef;
    localparam logic [7:0] C_LEAD_F0     = 8'hf0;
    localparam logic [7:0] C_LEAD_F4     = 8'hf4;
    localparam logic [7:0] C_SURR_TAG    = 8'ha0;
    localparam logic [7:0] C_CONT_BF     = 8'hbf;
    localparam logic [7:0] C_NONCHAR_TAG = 8'hbe;
    localparam logic [7:0] C_F4_CONT_MAX = 8'h8f;

    // continuation counts
    localparam logic [1:0] C_NEED_NONE   = 2'd0;
    localparam logic [1:0] C_NEED_ONE    = 2'd1;
    localparam logic [1:0] C_NEED_TWO    = 2'd2;
    localparam logic [1:0] C_NEED_THREE  = 2'd3;

    // open sequence and scan status
    typedef struct packed {
        logic [7:0] lead_byte;
        logic [7:0] second_byte;
        logic [1:0] bytes_expected;
        logic [1:0] bytes_seen;
        logic       error_found;
        logic       scan_stopped;
    } t_seq_state;

    // per-word events from the decoder
    typedef struct packed {
        logic lead_taken;
        logic bad;
    } t_step_flags;

endpackage

### hdl/utf8v_if.sv
// ----------------------------------------------------------------------------
// utf8v channel interfaces
// Valid/ready channels for the byte stream and for the verdict.
// ----------------------------------------------------------------------------
interface utf8v_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       is_last;

    modport source (output valid, output data_byte, output is_last, input ready);
    modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

interface utf8v_result_if;
    logic        valid;
    logic        ready;
    logic        malformed;
    logic [15:0] error_offset;

    modport source (output valid, output malformed, output error_offset, input ready);
    modport sink   (input valid, input malformed, input error_offset, output ready);
endinterface

### hdl/utf8_stream_validator.sv
// ----------------------------------------------------------------------------
// utf8_stream_validator
// Strict UTF-8 check of a byte string; one verdict per string at its last word.
// ----------------------------------------------------------------------------
//  channel      dir  payload                        word
//  i_byte_ch    in   data_byte[7:0], is_last        one string byte
//  o_result_ch  out  malformed, error_offset[15:0]  one verdict per string
//
//  one byte per cycle unless the input stalls: the decode sits between the
//  sequence state registers and the result register, so a word can be taken every cycle
//  i_rst_n is synchronous; it clears the sequence state and the result valid
//  the input stalls only when a verdict is held and the sink is not ready
//  the verdict is registered and appears in the cycle after the last byte is taken
// ----------------------------------------------------------------------------
module utf8_stream_validator #(
    parameter int OFFSET_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    utf8v_byte_if.sink       i_byte_ch,
    utf8v_result_if.source   o_result_ch
);
    import utf8v_pkg::*;

    localparam int OUT_BITS = 16;

    t_seq_state             r_seq;
    t_seq_state             n_seq;
    t_step_flags            step_flags;
    logic [OFFSET_BITS-1:0] r_byte_pos;
    logic [OFFSET_BITS-1:0] r_lead_pos;
    logic [OFFSET_BITS-1:0] r_err_pos;
    logic [OFFSET_BITS-1:0] n_err_pos;
    logic [OFFSET_BITS+OUT_BITS-1:0] err_pos_ext;
    logic                   r_out_valid;
    logic                   r_malformed;
    logic [OUT_BITS-1:0]    r_error_offset;
    logic                   in_acc;

    // handshake
    assign i_byte_ch.ready = !r_out_valid || o_result_ch.ready;
    assign in_acc          = i_byte_ch.valid && i_byte_ch.ready;

    // byte decode
    utf8v_step u_step (
        .i_state     (r_seq),
        .i_data_byte (i_byte_ch.data_byte),
        .i_is_last   (i_byte_ch.is_last),
        .o_state     (n_seq),
        .o_flags     (step_flags)
    );

    // position of the first malformed sequence
    always_comb begin
        n_err_pos = r_err_pos;
        if (step_flags.bad && !r_seq.error_found)
            n_err_pos = step_flags.lead_taken ? r_byte_pos : r_lead_pos;
    end

    assign err_pos_ext = {{OUT_BITS{1'b0}}, n_err_pos};

    // sequence state and offsets
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq      <= '0;
            r_byte_pos <= '0;
            r_lead_pos <= '0;
            r_err_pos  <= '0;
        end else if (in_acc) begin
            if (i_byte_ch.is_last) begin
                r_seq      <= '0;
                r_byte_pos <= '0;
                r_lead_pos <= '0;
                r_err_pos  <= '0;
            end else begin
                r_seq     <= n_seq;
                r_err_pos <= n_err_pos;
                if (step_flags.lead_taken)
                    r_lead_pos <= r_byte_pos;
                if (r_byte_pos != {OFFSET_BITS{1'b1}})
                    r_byte_pos <= r_byte_pos + 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && i_byte_ch.is_last) begin
            r_out_valid <= 1'b1;
        end else if (o_result_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_byte_ch.is_last) begin
            r_malformed    <= n_seq.error_found;
            r_error_offset <= n_seq.error_found ? err_pos_ext[OUT_BITS-1:0] : '0;
        end
    end

    assign o_result_ch.valid        = r_out_valid;
    assign o_result_ch.malformed    = r_malformed;
    assign o_result_ch.error_offset = r_error_offset;

    // checks
    a_no_valid_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid)
        else $error("result valid right after reset");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_byte_ch.is_last) |=> r_out_valid)
        else $error("last byte taken without a verdict");

    a_last_clears_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_byte_ch.is_last) |=>
        (r_seq == '0 && r_byte_pos == '0 && r_err_pos == '0))
        else $error("state not cleared after last byte");

    a_valid_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_malformed) |-> (r_error_offset == '0))
        else $error("nonzero offset on a valid string");

    a_error_stops_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seq.error_found |-> (r_seq.scan_stopped && r_seq.bytes_expected == C_NEED_NONE))
        else $error("scan still running after an error");

endmodule

### hdl/utf8v_step.sv
// ----------------------------------------------------------------------------
// utf8v_step
// Next-state decode for one byte: lead classification, continuation checks
// (overlong, surrogate, noncharacter, range) and the open-at-end check.
// ----------------------------------------------------------------------------
module utf8v_step (
    input  utf8v_pkg::t_seq_state  i_state,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_is_last,
    output utf8v_pkg::t_seq_state  o_state,
    output utf8v_pkg::t_step_flags o_flags
);
    import utf8v_pkg::*;

    logic [1:0] seen_inc;
    logic       cont_bad;
    logic       lead_bad;
    t_seq_state st;

    assign seen_inc = i_state.bytes_seen + 2'd1;

    // checks on a continuation word
    always_comb begin
        cont_bad = 1'b0;
        if ((i_data_byte & C_MASK_TOP2) != C_CONT_TAG) begin
            cont_bad = 1'b1;
        end else if (seen_inc == C_NEED_ONE) begin
            if (i_state.lead_byte == C_LEAD_E0 && (i_data_byte & C_MASK_TOP3) == C_CONT_TAG)
                cont_bad = 1'b1;
            if (i_state.lead_byte == C_LEAD_ED && (i_data_byte & C_MASK_TOP3) == C_SURR_TAG)
                cont_bad = 1'b1;
            if (i_state.lead_byte == C_LEAD_F0 && (i_data_byte & C_MASK_TOP4) == C_CONT_TAG)
                cont_bad = 1'b1;
            if (i_state.lead_byte == C_LEAD_F4 && i_data_byte > C_F4_CONT_MAX)
                cont_bad = 1'b1;
        end else if (seen_inc == C_NEED_TWO) begin
            if (i_state.lead_byte == C_LEAD_EF && i_state.second_byte == C_CONT_BF
                && (i_data_byte & C_MASK_TOP7) == C_NONCHAR_TAG)
                cont_bad = 1'b1;
        end
    end

    // sequence state update
    always_comb begin
        st       = i_state;
        lead_bad = 1'b0;
        o_flags  = '0;
        if (!i_state.scan_stopped) begin
            if (i_state.bytes_expected != C_NEED_NONE) begin
                // continuation slot
                if (cont_bad) begin
                    o_flags.bad = 1'b1;
                end else begin
                    if (seen_inc == C_NEED_ONE)
                        st.second_byte = i_data_byte;
                    if (seen_inc == i_state.bytes_expected) begin
                        st.bytes_expected = C_NEED_NONE;
                        st.bytes_seen     = C_NEED_NONE;
                    end else begin
                        st.bytes_seen = seen_inc;
                    end
                end
            end else begin
                // lead slot
                o_flags.lead_taken = 1'b1;
                st.lead_byte       = i_data_byte;
                st.bytes_seen      = C_NEED_NONE;
                if (i_data_byte == 8'h00) begin
                    st.scan_stopped = 1'b1;
                end else if (i_data_byte < C_CONT_TAG) begin
                    st.bytes_expected = C_NEED_NONE;
                end else if ((i_data_byte & C_MASK_TOP3) == C_LEAD2_TAG) begin
                    if ((i_data_byte & C_MASK_TOP7) == C_LEAD2_TAG) lead_bad = 1'b1;
                    else st.bytes_expected = C_NEED_ONE;
                end else if ((i_data_byte & C_MASK_TOP4) == C_LEAD3_TAG) begin
                    st.bytes_expected = C_NEED_TWO;
                end else if ((i_data_byte & C_MASK_TOP5) == C_LEAD4_TAG) begin
                    if (i_data_byte > C_LEAD_F4) lead_bad = 1'b1;
                    else st.bytes_expected = C_NEED_THREE;
                end else begin
                    lead_bad = 1'b1;
                end
                o_flags.bad = lead_bad;
            end
        end

        // sequence still open at the final word
        if (i_is_last && !o_flags.bad && !st.scan_stopped && st.bytes_expected != C_NEED_NONE)
            o_flags.bad = 1'b1;

        if (o_flags.bad) begin
            st.error_found    = 1'b1;
            st.scan_stopped   = 1'b1;
            st.bytes_expected = C_NEED_NONE;
            st.bytes_seen     = C_NEED_NONE;
        end
        o_state = st;
    end

endmodule

### sim/utf8_stream_validator_tb.sv
// ----------------------------------------------------------------------------
// utf8_stream_validator_tb
// Drives byte strings into the strict UTF-8 checker with random gaps on the
// input and random stalls on the verdict side. A scoreboard class mirrors the
// scan state per word and queues the verdict due at each last word, then
// compares every verdict field by field against the oldest one queued.
// ----------------------------------------------------------------------------
module utf8_stream_validator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import utf8v_pkg::*;

    localparam int OFFSET_BITS  = 16;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int TOTAL_BYTES  = 1950;
    localparam int LONG_RUN     = 200;

    // code points at the encoding boundaries
    localparam int unsigned BOUNDARY_CPS [11] = '{
        32'h1, 32'h7f, 32'h80, 32'h7ff, 32'h800, 32'hd7ff, 32'he000,
        32'hfffc, 32'hfffd, 32'h10000, 32'h10ffff
    };

    typedef logic [7:0] t_byte_q[$];

    typedef struct packed {
        logic        malformed;
        logic [15:0] error_offset;
    } t_verdict;

    // scan state mirror and queue of verdicts still owed by the block
    class utf8_verdict_board #(int POS_BITS = 16);
        t_verdict            pending_verdicts[$];
        int                  mismatches;
        int                  taken_bytes;
        logic [7:0]          lead_byte;
        logic [7:0]          second_byte;
        logic [1:0]          need_cont;
        logic [1:0]          seen_cont;
        logic [POS_BITS-1:0] byte_pos;
        logic [POS_BITS-1:0] lead_pos;
        logic [POS_BITS-1:0] first_bad_pos;
        logic                bad_seen;
        logic                scan_done;

        function new();
            mismatches  = 0;
            taken_bytes = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            lead_byte     = 8'h00;
            second_byte   = 8'h00;
            need_cont     = C_NEED_NONE;
            seen_cont     = C_NEED_NONE;
            byte_pos      = '0;
            lead_pos      = '0;
            first_bad_pos = '0;
            bad_seen      = 1'b0;
            scan_done     = 1'b0;
        endfunction

        // first error keeps its lead offset; the scan stops either way
        function void flag_bad();
            if (!bad_seen) begin
                bad_seen      = 1'b1;
                first_bad_pos = lead_pos;
            end
            scan_done = 1'b1;
            need_cont = C_NEED_NONE;
            seen_cont = C_NEED_NONE;
        endfunction

        // continuation slot: tag check, then overlong, surrogate, range and noncharacter checks
        function void take_cont(logic [7:0] b);
            logic bad = 1'b0;
            if ((b & C_MASK_TOP2) != C_CONT_TAG) begin
                flag_bad();
                return;
            end
            seen_cont = seen_cont + 2'd1;
            if (seen_cont == C_NEED_ONE) begin
                second_byte = b;
                if (lead_byte == C_LEAD_E0 && (b & C_MASK_TOP3) == C_CONT_TAG) bad = 1'b1;
                if (lead_byte == C_LEAD_ED && (b & C_MASK_TOP3) == C_SURR_TAG) bad = 1'b1;
                if (lead_byte == C_LEAD_F0 && (b & C_MASK_TOP4) == C_CONT_TAG) bad = 1'b1;
                if (lead_byte == C_LEAD_F4 && b > C_F4_CONT_MAX) bad = 1'b1;
            end else if (seen_cont == C_NEED_TWO) begin
                if (lead_byte == C_LEAD_EF && second_byte == C_CONT_BF &&
                    (b & C_MASK_TOP7) == C_NONCHAR_TAG) bad = 1'b1;
            end
            if (bad) begin
                flag_bad();
            end else if (seen_cont == need_cont) begin
                need_cont = C_NEED_NONE;
                seen_cont = C_NEED_NONE;
            end
        endfunction

        // lead slot: zero stops, ascii passes, a bad lead is flagged, otherwise open a sequence
        function void take_lead(logic [7:0] b);
            lead_pos  = byte_pos;
            lead_byte = b;
            seen_cont = C_NEED_NONE;
            if (b == 8'h00) begin
                scan_done = 1'b1;
            end else if ((b & C_CONT_TAG) == 8'h00) begin
                need_cont = C_NEED_NONE;
            end else if ((b & C_MASK_TOP3) == C_LEAD2_TAG) begin
                if ((b & C_MASK_TOP7) == C_LEAD2_TAG) flag_bad();
                else need_cont = C_NEED_ONE;
            end else if ((b & C_MASK_TOP4) == C_LEAD3_TAG) begin
                need_cont = C_NEED_TWO;
            end else if ((b & C_MASK_TOP5) == C_LEAD4_TAG) begin
                if (b > C_LEAD_F4) flag_bad();
                else need_cont = C_NEED_THREE;
            end else begin
                flag_bad();
            end
        endfunction

        // one accepted word; a last word queues the verdict and restarts the scan
        function void note_byte(logic [7:0] b, logic last);
            t_verdict v;
            taken_bytes++;
            if (!scan_done) begin
                if (need_cont != C_NEED_NONE) take_cont(b);
                else take_lead(b);
            end
            if (byte_pos != '1) byte_pos = byte_pos + 1'b1;
            if (last) begin
                if (!scan_done && need_cont != C_NEED_NONE) flag_bad();
                v.malformed    = bad_seen;
                v.error_offset = bad_seen ? 16'(first_bad_pos) : 16'd0;
                pending_verdicts.push_back(v);
                clear_scan();
            end
        endfunction

        function void check_verdict(logic m, logic [15:0] off);
            t_verdict want;
            if (pending_verdicts.size() == 0) begin
                $display("%0t: unexpected verdict malformed=%0b error_offset=%0d",
                         $time, m, off);
                mismatches++;
                return;
            end
            want = pending_verdicts.pop_front();
            if (m !== want.malformed) begin
                $display("%0t: malformed expected %0b actual %0b",
                         $time, want.malformed, m);
                mismatches++;
            end
            if (off !== want.error_offset) begin
                $display("%0t: error_offset expected %0d actual %0d",
                         $time, want.error_offset, off);
                mismatches++;
            end
        endfunction
    endclass

    typedef utf8_verdict_board #(OFFSET_BITS) t_board;

    logic i_clk;
    logic i_rst_n;
    int   cycle_count = 0;
    int   src_gap_max = 6;
    int   snk_stall_max = 6;

    utf8v_byte_if   byte_ch ();
    utf8v_result_if result_ch ();

    t_board board = new();

    utf8_stream_validator #(
        .OFFSET_BITS (OFFSET_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte_ch   (byte_ch),
        .o_result_ch (result_ch)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("utf8_stream_validator_tb: errors");
            $finish;
        end
    end

    // present one word after a random gap and wait for it to be taken
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        @(negedge i_clk);
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.is_last   <= last;
        @(posedge i_clk);
        while (byte_ch.ready !== 1'b1) @(posedge i_clk);
        board.note_byte(b, last);
    endtask

    task automatic send_string(input t_byte_q s);
        for (int i = 0; i < s.size(); i++) send_byte(s[i], i == s.size() - 1);
    endtask

    // hold the input off until every owed verdict has come back
    task automatic wait_drained();
        @(negedge i_clk);
        byte_ch.valid <= 1'b0;
        while (board.pending_verdicts.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] rand_cont();
        return C_CONT_TAG | 8'($urandom_range(0, 63));
    endfunction

    function automatic void add_char(ref t_byte_q q, input int unsigned cp);
        if (cp < 32'h80) begin
            q.push_back(8'(cp));
        end else if (cp < 32'h800) begin
            q.push_back(8'(C_LEAD2_TAG | (cp >> 6)));
            q.push_back(8'(C_CONT_TAG | (cp & 32'h3f)));
        end else if (cp < 32'h10000) begin
            q.push_back(8'(C_LEAD3_TAG | (cp >> 12)));
            q.push_back(8'(C_CONT_TAG | ((cp >> 6) & 32'h3f)));
            q.push_back(8'(C_CONT_TAG | (cp & 32'h3f)));
        end else begin
            q.push_back(8'(C_LEAD4_TAG | (cp >> 18)));
            q.push_back(8'(C_CONT_TAG | ((cp >> 12) & 32'h3f)));
            q.push_back(8'(C_CONT_TAG | ((cp >> 6) & 32'h3f)));
            q.push_back(8'(C_CONT_TAG | (cp & 32'h3f)));
        end
    endfunction

    // legal code point, biased toward ascii and encoding boundaries
    function automatic int unsigned pick_code_point();
        int unsigned cp;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: cp = $urandom_range(32'h1, 32'h7f);
            4:          cp = $urandom_range(32'h80, 32'h7ff);
            5: begin
                cp = $urandom_range(32'h800, 32'hfffd);
                if (cp >= 32'hd800 && cp <= 32'hdfff) cp = cp + 32'h800;
            end
            6:          cp = $urandom_range(32'h10000, 32'h10ffff);
            7:          cp = BOUNDARY_CPS[$urandom_range(0, 10)];
            8:          cp = $urandom_range(32'hfff0, 32'hfffd);
            default:    cp = $urandom_range(32'h20, 32'h7e);
        endcase
        return cp;
    endfunction

    // one broken sequence of a random kind, a zero byte or a random byte
    function automatic void add_flaw(ref t_byte_q q);
        t_byte_q part;
        int      drop;
        case ($urandom_range(0, 11))
            0: begin  // overlong two-byte form
                q.push_back(C_LEAD2_TAG | 8'($urandom_range(0, 1)));
                q.push_back(rand_cont());
            end
            1: begin  // overlong three-byte form
                q.push_back(C_LEAD_E0);
                q.push_back(C_CONT_TAG | 8'($urandom_range(0, 31)));
                q.push_back(rand_cont());
            end
            2: begin  // overlong four-byte form
                q.push_back(C_LEAD_F0);
                q.push_back(C_CONT_TAG | 8'($urandom_range(0, 15)));
                q.push_back(rand_cont());
                q.push_back(rand_cont());
            end
            3: begin  // surrogate
                q.push_back(C_LEAD_ED);
                q.push_back(C_SURR_TAG | 8'($urandom_range(0, 31)));
                q.push_back(rand_cont());
            end
            4: begin  // U+FFFE or U+FFFF
                q.push_back(C_LEAD_EF);
                q.push_back(C_CONT_BF);
                q.push_back(C_NONCHAR_TAG | 8'($urandom_range(0, 1)));
            end
            5: begin  // above U+10FFFF
                q.push_back(C_LEAD_F4);
                q.push_back(8'($urandom_range(8'h90, 8'hbf)));
                q.push_back(rand_cont());
                q.push_back(rand_cont());
            end
            6: begin  // lead beyond F4
                q.push_back(8'($urandom_range(8'hf5, 8'hff)));
                q.push_back(rand_cont());
            end
            7: q.push_back(8'($urandom_range(8'h80, 8'hbf)));
            8: begin  // sequence cut short
                add_char(part, $urandom_range(32'h80, 32'h10ffff));
                if (part.size() == 3 && part[0] == C_LEAD_ED) part[1] = C_CONT_TAG;
                drop = $urandom_range(1, part.size() - 1);
                repeat (drop) void'(part.pop_back());
                foreach (part[i]) q.push_back(part[i]);
            end
            9:  q.push_back(8'h00);
            10: q.push_back(8'($urandom_range(0, 255)));
            default: begin  // open lead followed by a non-continuation
                q.push_back(8'($urandom_range(8'hc2, 8'hf4)));
                case ($urandom_range(0, 2))
                    0:       q.push_back(8'h00);
                    1:       q.push_back(8'($urandom_range(8'h01, 8'h7f)));
                    default: q.push_back(8'($urandom_range(8'hc0, 8'hff)));
                endcase
            end
        endcase
    endfunction

    // mostly well-formed text, some with one flaw, a few of pure noise
    function automatic t_byte_q build_string();
        t_byte_q s;
        int      n_chars;
        int      flaw_at;
        if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 8)) s.push_back(8'($urandom_range(0, 255)));
            return s;
        end
        n_chars = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        flaw_at = ($urandom_range(0, 99) < 35) ? $urandom_range(0, n_chars) : -1;
        for (int i = 0; i <= n_chars; i++) begin
            if (i == flaw_at) add_flaw(s);
            if (i < n_chars) add_char(s, pick_code_point());
        end
        return s;
    endfunction

    // verdict side: random stall before each verdict
    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            stall = $urandom_range(0, snk_stall_max);
            if (stall > 0) begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!(result_ch.valid === 1'b1 && result_ch.ready === 1'b1)) @(posedge i_clk);
            board.check_verdict(result_ch.malformed, result_ch.error_offset);
        end
    end

    // stimulus
    initial begin
        t_byte_q s;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = 8'h00;
        byte_ch.is_last   = 1'b0;
        result_ch.ready   = 1'b0;
        i_rst_n           = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // zero byte alone, then the ascii top and a minimal two-byte form
        s = {8'h00};                       send_string(s);
        s = {8'h7f, 8'hc2, 8'h80};         send_string(s);
        // early lead error, following word ignored
        s = {8'hc0, 8'haf};                send_string(s);
        // surrogate and noncharacter
        s = {8'hed, 8'ha0, 8'h80};         send_string(s);
        s = {8'hef, 8'hbf, 8'hbf};         send_string(s);
        // above the last code point, seen on the first continuation
        s = {8'hf4, 8'h90};                send_string(s);
        // all ones as a lead
        s = {8'hff};                       send_string(s);
        // zero in a continuation slot
        s = {8'he2, 8'h00, 8'h41};         send_string(s);
        // sequence open at the last word
        s = {8'h41, 8'he2, 8'h82};         send_string(s);
        // words after a zero are ignored
        s = {8'h41, 8'h00, 8'hff};         send_string(s);
        wait_drained();

        // long string with no idling, words back to back
        src_gap_max   = 0;
        snk_stall_max = 0;
        repeat (LONG_RUN) send_byte(8'($urandom_range(8'h01, 8'h7f)), 1'b0);
        send_byte(8'hff, 1'b1);
        wait_drained();

        // random strings with changing idle patterns
        src_gap_max   = 6;
        snk_stall_max = 6;
        while (board.taken_bytes < TOTAL_BYTES) begin
            if ($urandom_range(0, 9) == 0) begin
                src_gap_max   = ($urandom_range(0, 2) == 0) ? 0 : 6;
                snk_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 6;
            end
            if ($urandom_range(0, 39) == 0) wait_drained();
            s = build_string();
            send_string(s);
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (board.mismatches == 0) begin
            $display("utf8_stream_validator_tb: clean");
        end else begin
            $display("utf8_stream_validator_tb: errors");
        end
        $finish;
    end

endmodule
